/* rtl/brss_pkg.sv */
// ----------------------------------------------------------------------------
// brss_pkg
// Shared types and constants for the byte range sector splitter.
// ----------------------------------------------------------------------------
package brss_pkg;

  localparam int unsigned SectorBytes     = 512;
  localparam int unsigned SectorShift     = 9;
  localparam int unsigned MaxChunkSectors = 256;
  localparam int unsigned MaxLength       = 4194304;

  localparam int unsigned LbaW    = 32;
  localparam int unsigned SecInW  = 28;
  localparam int unsigned OffW    = 16;
  localparam int unsigned LenW    = 23;
  localparam int unsigned CountW  = 9;
  localparam int unsigned FirstW  = 9;
  localparam int unsigned BytesW  = 10;
  localparam int unsigned CfgIdxW = 3;

  // request commands
  localparam logic [1:0] CMD_READ      = 2'd0;
  localparam logic [1:0] CMD_WRITE     = 2'd1;
  localparam logic [1:0] CMD_PART_READ = 2'd2;
  localparam logic [1:0] CMD_NONE      = 2'd3;

  // emitted operation kinds
  localparam logic [1:0] OP_RD_WHOLE = 2'd0;
  localparam logic [1:0] OP_WR_WHOLE = 2'd1;
  localparam logic [1:0] OP_RD_PART  = 2'd2;
  localparam logic [1:0] OP_RMW      = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DMA_ENABLE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PART0      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PART1      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PART2      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PART3      = 3'd4;

  typedef struct packed {
    logic [1:0]        op_kind;
    logic [LbaW-1:0]   lba;
    logic [CountW-1:0] sector_count;
    logic [FirstW-1:0] first_byte;
    logic [BytesW-1:0] byte_count;
    logic [LenW-1:0]   buffer_position;
    logic              uses_dma;
    logic              last;
  } res_t;

endpackage

/* rtl/brss_alu.sv */
// ----------------------------------------------------------------------------
// brss_alu
// Shared 32-bit sector adder used for every LBA computation.
// ----------------------------------------------------------------------------
module brss_alu (
  input  logic [brss_pkg::LbaW-1:0] a_i,
  input  logic [brss_pkg::LbaW-1:0] b_i,
  output logic [brss_pkg::LbaW-1:0] sum_o
);

  // wraps at 32 bits
  assign sum_o = a_i + b_i;

endmodule

/* rtl/brss_seq.sv */
// ----------------------------------------------------------------------------
// brss_seq
// Sequencer: folds the byte offset into the sector, then walks the head,
// whole-sector chunks and tail, one command per cycle.
// ----------------------------------------------------------------------------
module brss_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [1:0]                    cmd_i,
  input  logic [brss_pkg::LbaW-1:0]     base_i,
  input  logic [brss_pkg::SecInW-1:0]   start_sector_i,
  input  logic [brss_pkg::OffW-1:0]     byte_offset_i,
  input  logic [brss_pkg::LenW-1:0]     byte_length_i,
  input  logic                          dma_i,
  output logic [brss_pkg::LbaW-1:0]     alu_a_o,
  output logic [brss_pkg::LbaW-1:0]     alu_b_o,
  input  logic [brss_pkg::LbaW-1:0]     alu_sum_i,
  output logic                          busy_o,
  output logic                          res_valid_o,
  output brss_pkg::res_t                res_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FOLD = 2'd1;
  localparam logic [1:0] S_HEAD = 2'd2;
  localparam logic [1:0] S_BODY = 2'd3;

  localparam int unsigned WholeW = brss_pkg::LenW - brss_pkg::SectorShift;
  localparam int unsigned ChunkW = brss_pkg::CountW + brss_pkg::SectorShift;

  logic [1:0] state_q, state_d;
  logic [brss_pkg::LbaW-1:0]   lba_q, lba_d;
  logic [brss_pkg::LenW-1:0]   len_q, len_d;
  logic [brss_pkg::LenW-1:0]   pos_q, pos_d;
  logic [brss_pkg::OffW-1:0]   off_q, off_d;
  logic                        wr_q, wr_d;
  logic                        valid_q, valid_d;
  brss_pkg::res_t              res_q, res_d;

  logic                        accept;
  logic [brss_pkg::LenW-1:0]   len_sat;
  logic [brss_pkg::FirstW-1:0] in_off;
  logic [brss_pkg::BytesW-1:0] take_max, take;
  logic                        head_last;
  logic [WholeW-1:0]           whole;
  logic [brss_pkg::FirstW-1:0] rem;
  logic [brss_pkg::CountW-1:0] cnt;
  logic [ChunkW-1:0]           chunk_bytes;
  logic                        body_last;
  logic [1:0]                  part_kind, whole_kind;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  assign len_sat = (byte_length_i > brss_pkg::LenW'(brss_pkg::MaxLength))
                   ? brss_pkg::LenW'(brss_pkg::MaxLength) : byte_length_i;

  assign in_off   = off_q[brss_pkg::FirstW-1:0];
  assign take_max = brss_pkg::BytesW'(brss_pkg::SectorBytes) - {1'b0, in_off};
  assign head_last = (len_q <= brss_pkg::LenW'(take_max));
  assign take     = head_last ? len_q[brss_pkg::BytesW-1:0] : take_max;

  assign whole = len_q[brss_pkg::LenW-1:brss_pkg::SectorShift];
  assign rem   = len_q[brss_pkg::SectorShift-1:0];
  assign cnt   = (whole > WholeW'(brss_pkg::MaxChunkSectors))
                 ? brss_pkg::CountW'(brss_pkg::MaxChunkSectors)
                 : whole[brss_pkg::CountW-1:0];
  assign chunk_bytes = {cnt, {brss_pkg::SectorShift{1'b0}}};
  assign body_last   = (WholeW'(cnt) == whole) && (rem == '0);

  assign part_kind  = wr_q ? brss_pkg::OP_RMW : brss_pkg::OP_RD_PART;
  assign whole_kind = wr_q ? brss_pkg::OP_WR_WHOLE : brss_pkg::OP_RD_WHOLE;

  // shared adder operand select
  always_comb begin
    unique case (state_q)
      S_IDLE: begin
        alu_a_o = brss_pkg::LbaW'(start_sector_i);
        alu_b_o = base_i;
      end
      S_FOLD: begin
        alu_a_o = lba_q;
        alu_b_o = brss_pkg::LbaW'(off_q[brss_pkg::OffW-1:brss_pkg::SectorShift]);
      end
      S_HEAD: begin
        alu_a_o = lba_q;
        alu_b_o = brss_pkg::LbaW'(1);
      end
      S_BODY: begin
        alu_a_o = lba_q;
        alu_b_o = brss_pkg::LbaW'(cnt);
      end
      default: begin
        alu_a_o = lba_q;
        alu_b_o = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    lba_d   = lba_q;
    len_d   = len_q;
    pos_d   = pos_q;
    off_d   = off_q;
    wr_d    = wr_q;
    valid_d = 1'b0;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          lba_d = alu_sum_i;
          len_d = len_sat;
          off_d = byte_offset_i;
          pos_d = '0;
          wr_d  = (cmd_i == brss_pkg::CMD_WRITE);
          // unknown command or empty range emits nothing
          if (cmd_i != brss_pkg::CMD_NONE && len_sat != '0) begin
            state_d = S_FOLD;
          end
        end
      end
      S_FOLD: begin
        lba_d   = alu_sum_i;
        state_d = S_HEAD;
      end
      S_HEAD: begin
        if (in_off != '0) begin
          valid_d               = 1'b1;
          res_d.op_kind         = part_kind;
          res_d.lba             = lba_q;
          res_d.sector_count    = brss_pkg::CountW'(1);
          res_d.first_byte      = in_off;
          res_d.byte_count      = take;
          res_d.buffer_position = '0;
          res_d.uses_dma        = dma_i;
          res_d.last            = head_last;
          lba_d = alu_sum_i;
          len_d = len_q - brss_pkg::LenW'(take);
          pos_d = brss_pkg::LenW'(take);
          state_d = head_last ? S_IDLE : S_BODY;
        end else begin
          state_d = S_BODY;
        end
      end
      S_BODY: begin
        valid_d               = 1'b1;
        res_d.lba             = lba_q;
        res_d.buffer_position = pos_q;
        if (whole != '0) begin
          res_d.op_kind      = whole_kind;
          res_d.sector_count = cnt;
          res_d.first_byte   = '0;
          res_d.byte_count   = '0;
          res_d.uses_dma     = wr_q ? 1'b0 : dma_i;
          res_d.last         = body_last;
          lba_d = alu_sum_i;
          len_d = len_q - brss_pkg::LenW'(chunk_bytes);
          pos_d = pos_q + brss_pkg::LenW'(chunk_bytes);
          if (body_last) begin
            state_d = S_IDLE;
          end
        end else begin
          // tail partial sector
          res_d.op_kind      = part_kind;
          res_d.sector_count = brss_pkg::CountW'(1);
          res_d.first_byte   = '0;
          res_d.byte_count   = brss_pkg::BytesW'(rem);
          res_d.uses_dma     = dma_i;
          res_d.last         = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lba_q <= lba_d;
    len_q <= len_d;
    pos_q <= pos_d;
    off_q <= off_d;
    wr_q  <= wr_d;
    res_q <= res_d;
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

/* rtl/byte_range_sector_splitter.sv */
// ----------------------------------------------------------------------------
// byte_range_sector_splitter
// Splits a byte-range disk transfer into head, whole-sector chunk and tail
// sector commands.
// ----------------------------------------------------------------------------
//   channel  | handshake                  | payload
//   ---------+----------------------------+----------------------------------
//   request  | start / busy               | cmd, partition, sector, offset, len
//   command  | res_valid_o strobe         | op_kind .. last, one per cycle
//   config   | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// A request runs its setup steps (partition add, offset fold, head) on
// the shared LBA adder, then walks the whole-sector chunks and the tail.
// Commands are registered and appear in the cycle after they are formed, one per cycle.
// busy stays high until the last command is formed; the receiver cannot stall.
// Reset clears the config registers and the sequencer state and valid flag; config is always ready.
module byte_range_sector_splitter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        cmd_i,
  input  logic [1:0]                        partition_i,
  input  logic [brss_pkg::SecInW-1:0]       start_sector_i,
  input  logic [brss_pkg::OffW-1:0]         byte_offset_i,
  input  logic [brss_pkg::LenW-1:0]         byte_length_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [brss_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [brss_pkg::LbaW-1:0]         cfg_data_i,
  output logic                              res_valid_o,
  output logic [1:0]                        op_kind_o,
  output logic [brss_pkg::LbaW-1:0]         lba_o,
  output logic [brss_pkg::CountW-1:0]       sector_count_o,
  output logic [brss_pkg::FirstW-1:0]       first_byte_o,
  output logic [brss_pkg::BytesW-1:0]       byte_count_o,
  output logic [brss_pkg::LenW-1:0]         buffer_position_o,
  output logic                              uses_dma_o,
  output logic                              last_o
);

  logic                         dma_q;
  logic [brss_pkg::LbaW-1:0]    part_q [4];
  logic [brss_pkg::LbaW-1:0]    base;
  logic [brss_pkg::LbaW-1:0]    alu_a, alu_b, alu_sum;
  brss_pkg::res_t               res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dma_q     <= 1'b0;
      part_q[0] <= '0;
      part_q[1] <= '0;
      part_q[2] <= '0;
      part_q[3] <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        brss_pkg::CFG_DMA_ENABLE: dma_q     <= cfg_data_i[0];
        brss_pkg::CFG_PART0:      part_q[0] <= cfg_data_i;
        brss_pkg::CFG_PART1:      part_q[1] <= cfg_data_i;
        brss_pkg::CFG_PART2:      part_q[2] <= cfg_data_i;
        brss_pkg::CFG_PART3:      part_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // partition base only for partition-relative reads
  assign base = (cmd_i == brss_pkg::CMD_PART_READ) ? part_q[partition_i] : '0;

  brss_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sum_o (alu_sum)
  );

  brss_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .cmd_i          (cmd_i),
    .base_i         (base),
    .start_sector_i (start_sector_i),
    .byte_offset_i  (byte_offset_i),
    .byte_length_i  (byte_length_i),
    .dma_i          (dma_q),
    .alu_a_o        (alu_a),
    .alu_b_o        (alu_b),
    .alu_sum_i      (alu_sum),
    .busy_o         (busy),
    .res_valid_o    (res_valid_o),
    .res_o          (res)
  );

  assign op_kind_o         = res.op_kind;
  assign lba_o             = res.lba;
  assign sector_count_o    = res.sector_count;
  assign first_byte_o      = res.first_byte;
  assign byte_count_o      = res.byte_count;
  assign buffer_position_o = res.buffer_position;
  assign uses_dma_o        = res.uses_dma;
  assign last_o            = res.last;

endmodule

/* rtl/brss_checker.sv */
// ----------------------------------------------------------------------------
// brss_checker
// Port-level checks for the byte range sector splitter, bound to the top.
// ----------------------------------------------------------------------------
module brss_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic [1:0]                    cmd_i,
  input logic [brss_pkg::LenW-1:0]     byte_length_i,
  input logic                          res_valid_o,
  input logic [1:0]                    op_kind_o,
  input logic [brss_pkg::CountW-1:0]   sector_count_o,
  input logic [brss_pkg::FirstW-1:0]   first_byte_o,
  input logic [brss_pkg::BytesW-1:0]   byte_count_o,
  input logic                          uses_dma_o
);

  // ignored requests never occupy the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (cmd_i == brss_pkg::CMD_NONE || byte_length_i == '0) |=> !busy)
    else $error("ignored request left block busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (op_kind_o == brss_pkg::OP_RD_WHOLE || op_kind_o == brss_pkg::OP_WR_WHOLE)
    |-> (byte_count_o == '0) && (first_byte_o == '0) && (sector_count_o != '0))
    else $error("whole-sector command carries byte range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (op_kind_o == brss_pkg::OP_RD_PART || op_kind_o == brss_pkg::OP_RMW)
    |-> (sector_count_o == brss_pkg::CountW'(1)) && (byte_count_o != '0))
    else $error("partial command malformed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (op_kind_o == brss_pkg::OP_WR_WHOLE) |-> !uses_dma_o)
    else $error("whole-sector write marked as DMA");

endmodule

bind byte_range_sector_splitter brss_checker u_brss_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .cmd_i          (cmd_i),
  .byte_length_i  (byte_length_i),
  .res_valid_o    (res_valid_o),
  .op_kind_o      (op_kind_o),
  .sector_count_o (sector_count_o),
  .first_byte_o   (first_byte_o),
  .byte_count_o   (byte_count_o),
  .uses_dma_o     (uses_dma_o)
);
